>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types, constants and the micro-program of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

	localparam int W        = 32;
	localparam int QDEPTH   = 2;
	localparam int PROG_LEN = 31;
	localparam int PC_W     = $clog2(PROG_LEN);
	localparam int CNT_W    = $clog2(W + 1);
	localparam int K_W      = $clog2(W);
	localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam int IN_TDATA_W  = ((4 * W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((2 * W + 7) / 8) * 8;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_OVF  = 2'd2;

	localparam logic [PC_W-1:0] PC_LIN = PC_W'(0);
	localparam logic [PC_W-1:0] PC_MUL = PC_W'(13);
	localparam logic [PC_W-1:0] PC_DIV = PC_W'(20);

	localparam logic [CNT_W-1:0]  DIV_STEPS = CNT_W'(W);
	localparam logic [QPTR_W-1:0] QLAST     = QPTR_W'(QDEPTH - 1);
	localparam logic [QCNT_W-1:0] QFULL     = QCNT_W'(QDEPTH);

	localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W - 1){1'b0}}};
	localparam logic [2*W-1:0] MAG_NEG = (2 * W)'(1) << (W - 1);
	localparam logic [2*W-1:0] MAG_POS = MAG_NEG - (2 * W)'(1);

	typedef enum logic [2:0] {K_MUL, K_DIV, K_GCD, K_ADD, K_FIX, K_END} kind_t;
	typedef enum logic [2:0] {R_AN, R_AD, R_BN, R_BD, R_T0, R_T1, R_T2} reg_t;

	typedef struct packed {
		kind_t kind;
		reg_t  a;
		reg_t  b;
		reg_t  d;
	} uop_t;

	typedef struct packed {
		logic                   sub;
		logic [PC_W-1:0]        entry;
		logic signed [W-1:0]    a_num;
		logic signed [W-1:0]    a_den;
		logic signed [W-1:0]    b_num;
		logic signed [W-1:0]    b_den;
	} item_t;

	function automatic uop_t mk(input kind_t k, input reg_t a, input reg_t b, input reg_t d);
		uop_t u;
		u.kind = k;
		u.a    = a;
		u.b    = b;
		u.d    = d;
		return u;
	endfunction

	// t0 holds the denominator side, t1 the numerator side, t2 scratch / gcd
	function automatic uop_t rom(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			// add / subtract over the lcm
			PC_W'(0):  u = mk(K_MUL, R_AD, R_BD, R_T0);
			PC_W'(1):  u = mk(K_GCD, R_AD, R_BD, R_T1);
			PC_W'(2):  u = mk(K_DIV, R_T0, R_T1, R_T0);
			PC_W'(3):  u = mk(K_DIV, R_T0, R_AD, R_T1);
			PC_W'(4):  u = mk(K_MUL, R_AN, R_T1, R_T1);
			PC_W'(5):  u = mk(K_DIV, R_T0, R_BD, R_T2);
			PC_W'(6):  u = mk(K_MUL, R_BN, R_T2, R_T2);
			PC_W'(7):  u = mk(K_ADD, R_T1, R_T2, R_T1);
			PC_W'(8):  u = mk(K_GCD, R_T1, R_T0, R_T2);
			PC_W'(9):  u = mk(K_DIV, R_T1, R_T2, R_T1);
			PC_W'(10): u = mk(K_DIV, R_T0, R_T2, R_T0);
			PC_W'(11): u = mk(K_FIX, R_T1, R_T0, R_T1);
			PC_W'(12): u = mk(K_END, R_T1, R_T0, R_T1);
			// multiply
			PC_W'(13): u = mk(K_MUL, R_AN, R_BN, R_T1);
			PC_W'(14): u = mk(K_MUL, R_AD, R_BD, R_T0);
			PC_W'(15): u = mk(K_GCD, R_T1, R_T0, R_T2);
			PC_W'(16): u = mk(K_DIV, R_T1, R_T2, R_T1);
			PC_W'(17): u = mk(K_DIV, R_T0, R_T2, R_T0);
			PC_W'(18): u = mk(K_FIX, R_T1, R_T0, R_T1);
			PC_W'(19): u = mk(K_END, R_T1, R_T0, R_T1);
			// divide: reduce the inverted right operand, then multiply
			PC_W'(20): u = mk(K_GCD, R_BD, R_BN, R_T2);
			PC_W'(21): u = mk(K_DIV, R_BD, R_T2, R_T1);
			PC_W'(22): u = mk(K_DIV, R_BN, R_T2, R_T0);
			PC_W'(23): u = mk(K_FIX, R_T1, R_T0, R_T1);
			PC_W'(24): u = mk(K_MUL, R_AN, R_T1, R_T1);
			PC_W'(25): u = mk(K_MUL, R_AD, R_T0, R_T0);
			PC_W'(26): u = mk(K_GCD, R_T1, R_T0, R_T2);
			PC_W'(27): u = mk(K_DIV, R_T1, R_T2, R_T1);
			PC_W'(28): u = mk(K_DIV, R_T0, R_T2, R_T0);
			PC_W'(29): u = mk(K_FIX, R_T1, R_T0, R_T1);
			default:   u = mk(K_END, R_T1, R_T0, R_T1);
		endcase
		return u;
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
		return v[W-1] ? W'(-v) : W'(v);
	endfunction

	function automatic logic [OUT_TDATA_W-1:0] pack_out(input logic [W-1:0] num,
		input logic [W-1:0] den);
		return OUT_TDATA_W'({den, num});
	endfunction

endpackage

>>> rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Adds, subtracts, multiplies or divides two fractions and returns the
// reduced fraction with an error code.
// ----------------------------------------------------------------------------
// One result per transaction. An item that runs to the end passes through the whole
// micro-program in the execution sequencer; a fault ends it early. Each divide runs
// in the bit-serial restoring divider (add/subtract use five, multiply two, divide
// four), each gcd in the binary gcd loop (two for add/subtract, one for multiply,
// two for divide), and each multiply in the shared multiplier. The input stage and
// a two-entry queue accept up to three further items while one executes, and a
// finished result waits in the output register without holding up the next item's
// work.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rau_pkg::IN_TDATA_W-1:0]    s_tdata,  // a_num, a_den, b_num, b_den
	input  logic [1:0]                        s_tuser,  // op
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rau_pkg::OUT_TDATA_W-1:0]   m_tdata,  // res_num, res_den
	output logic [1:0]                        m_tuser   // error
);

	logic           f_valid, f_ready;
	rau_pkg::item_t f_item;
	logic           q_valid, q_ready;
	rau_pkg::item_t q_item;

	rau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	rau_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_item  (f_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (q_item)
	);

	rau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> rtl/rau_front.sv
// ----------------------------------------------------------------------------
// rau_front
// Input stage: takes a transaction, decodes the operation into a program entry.
// ----------------------------------------------------------------------------
module rau_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rau_pkg::IN_TDATA_W-1:0]   s_tdata,  // a_num, a_den, b_num, b_den
	input  logic [1:0]                       s_tuser,  // op
	output logic                             item_valid,
	input  logic                             item_ready,
	output rau_pkg::item_t                   item
);

	logic           valid_s1;
	rau_pkg::item_t item_s1;
	rau_pkg::item_t dec;

	assign s_tready   = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item       = item_s1;

	always_comb begin
		dec.a_num = s_tdata[rau_pkg::W-1:0];
		dec.a_den = s_tdata[2*rau_pkg::W-1:rau_pkg::W];
		dec.b_num = s_tdata[3*rau_pkg::W-1:2*rau_pkg::W];
		dec.b_den = s_tdata[4*rau_pkg::W-1:3*rau_pkg::W];
		unique case (s_tuser)
			rau_pkg::OP_ADD: begin
				dec.sub   = 1'b0;
				dec.entry = rau_pkg::PC_LIN;
			end
			rau_pkg::OP_SUB: begin
				dec.sub   = 1'b1;
				dec.entry = rau_pkg::PC_LIN;
			end
			rau_pkg::OP_MUL: begin
				dec.sub   = 1'b0;
				dec.entry = rau_pkg::PC_MUL;
			end
			default: begin
				dec.sub   = 1'b0;
				dec.entry = rau_pkg::PC_DIV;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= dec;
		end
	end

endmodule

>>> rtl/rau_queue.sv
// ----------------------------------------------------------------------------
// rau_queue
// Short fifo between the input stage and the execution sequencer.
// ----------------------------------------------------------------------------
module rau_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  rau_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output rau_pkg::item_t pop_item
);

	rau_pkg::item_t                mem_q [rau_pkg::QDEPTH];
	logic [rau_pkg::QPTR_W-1:0]    wp_q;
	logic [rau_pkg::QPTR_W-1:0]    rp_q;
	logic [rau_pkg::QCNT_W-1:0]    cnt_q;
	logic                          push;
	logic                          pop;

	assign push_ready = (cnt_q != rau_pkg::QFULL);
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rp_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == rau_pkg::QLAST) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == rau_pkg::QLAST) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

endmodule

>>> rtl/rau_back.sv
// ----------------------------------------------------------------------------
// rau_back
// Execution sequencer: runs the micro-program on a shared multiplier,
// restoring divider and binary gcd unit, then holds the result for output.
// ----------------------------------------------------------------------------
module rau_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_ready,
	input  rau_pkg::item_t                    q_item,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rau_pkg::OUT_TDATA_W-1:0]   m_tdata,  // res_num, res_den
	output logic [1:0]                        m_tuser   // error
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_EXEC  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic signed [rau_pkg::W-1:0] an_q, ad_q, bn_q, bd_q, t0_q, t1_q, t2_q;
	logic                         sub_q;
	logic [rau_pkg::PC_W-1:0]     pc_q;
	logic [1:0]                   fault_q;
	rau_pkg::kind_t               kind_q;
	rau_pkg::reg_t                dst_q;
	logic                         neg_q;
	logic [2*rau_pkg::W-1:0]      prod_q;
	logic [rau_pkg::W-1:0]        dq_q, dr_q, dy_q;
	logic [rau_pkg::CNT_W-1:0]    cnt_q;
	logic [rau_pkg::W-1:0]        gx_q, gy_q;
	logic [rau_pkg::K_W-1:0]      gk_q;
	logic                         m_tvalid_q;
	logic [rau_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic [1:0]                   m_tuser_q;

	rau_pkg::uop_t                uop;
	logic signed [rau_pkg::W-1:0] opx, opy;
	logic signed [rau_pkg::W:0]   sum_w;
	logic                         go_exec;
	logic                         adv;
	logic                         wr_en;
	logic [rau_pkg::W-1:0]        wr_val;
	rau_pkg::reg_t                wr_sel;
	logic [1:0]                   flt;
	logic                         fix_en;
	logic [rau_pkg::W:0]          rem_sh, rem_diff;
	logic                         rem_ge;
	logic                         out_load;

	assign uop      = rau_pkg::rom(pc_q);
	assign q_ready  = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	always_comb begin
		case (uop.a)
			rau_pkg::R_AN: opx = an_q;
			rau_pkg::R_AD: opx = ad_q;
			rau_pkg::R_BN: opx = bn_q;
			rau_pkg::R_BD: opx = bd_q;
			rau_pkg::R_T0: opx = t0_q;
			rau_pkg::R_T1: opx = t1_q;
			rau_pkg::R_T2: opx = t2_q;
			default:       opx = '0;
		endcase
		case (uop.b)
			rau_pkg::R_AN: opy = an_q;
			rau_pkg::R_AD: opy = ad_q;
			rau_pkg::R_BN: opy = bn_q;
			rau_pkg::R_BD: opy = bd_q;
			rau_pkg::R_T0: opy = t0_q;
			rau_pkg::R_T1: opy = t1_q;
			rau_pkg::R_T2: opy = t2_q;
			default:       opy = '0;
		endcase
	end

	assign sum_w = sub_q ? ({opx[rau_pkg::W-1], opx} - {opy[rau_pkg::W-1], opy})
	                     : ({opx[rau_pkg::W-1], opx} + {opy[rau_pkg::W-1], opy});

	// one restoring division step
	assign rem_sh   = {dr_q, dq_q[rau_pkg::W-1]};
	assign rem_ge   = rem_sh >= {1'b0, dy_q};
	assign rem_diff = rem_sh - {1'b0, dy_q};

	always_comb begin
		go_exec = 1'b0;
		adv     = 1'b0;
		wr_en   = 1'b0;
		wr_val  = '0;
		flt     = rau_pkg::ERR_NONE;
		fix_en  = 1'b0;
		wr_sel  = dst_q;
		if (state_q == S_ISSUE && fault_q == rau_pkg::ERR_NONE) begin
			wr_sel = uop.d;
			case (uop.kind)
				rau_pkg::K_MUL: go_exec = 1'b1;
				rau_pkg::K_DIV: begin
					if (opy == '0) begin
						flt = rau_pkg::ERR_DIV0;
						adv = 1'b1;
					end else begin
						go_exec = 1'b1;
					end
				end
				rau_pkg::K_GCD: begin
					if (opx == rau_pkg::MIN_VAL || opy == rau_pkg::MIN_VAL) begin
						flt = rau_pkg::ERR_OVF;
						adv = 1'b1;
					end else begin
						go_exec = 1'b1;
					end
				end
				rau_pkg::K_ADD: begin
					adv = 1'b1;
					if (sum_w[rau_pkg::W] != sum_w[rau_pkg::W-1]) begin
						flt = rau_pkg::ERR_OVF;
					end else begin
						wr_en  = 1'b1;
						wr_val = sum_w[rau_pkg::W-1:0];
					end
				end
				rau_pkg::K_FIX: begin
					adv = 1'b1;
					if (t1_q[rau_pkg::W-1] && t0_q[rau_pkg::W-1]) begin
						if (t1_q == rau_pkg::MIN_VAL || t0_q == rau_pkg::MIN_VAL) begin
							flt = rau_pkg::ERR_OVF;
						end else begin
							fix_en = 1'b1;
						end
					end
				end
				default: ;
			endcase
		end else if (state_q == S_EXEC) begin
			case (kind_q)
				rau_pkg::K_MUL: begin
					adv = 1'b1;
					if (prod_q > (neg_q ? rau_pkg::MAG_NEG : rau_pkg::MAG_POS)) begin
						flt = rau_pkg::ERR_OVF;
					end else begin
						wr_en  = 1'b1;
						wr_val = neg_q ? -prod_q[rau_pkg::W-1:0] : prod_q[rau_pkg::W-1:0];
					end
				end
				rau_pkg::K_DIV: begin
					if (cnt_q == rau_pkg::DIV_STEPS) begin
						adv = 1'b1;
						if (!neg_q && dq_q[rau_pkg::W-1]) begin
							flt = rau_pkg::ERR_OVF;
						end else begin
							wr_en  = 1'b1;
							wr_val = neg_q ? -dq_q : dq_q;
						end
					end
				end
				rau_pkg::K_GCD: begin
					if (gx_q == '0) begin
						adv    = 1'b1;
						wr_en  = 1'b1;
						wr_val = gy_q << gk_q;
					end else if (gy_q == '0) begin
						adv    = 1'b1;
						wr_en  = 1'b1;
						wr_val = gx_q << gk_q;
					end
				end
				default: adv = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (fault_q != rau_pkg::ERR_NONE || uop.kind == rau_pkg::K_END) begin
						state_q <= S_DONE;
					end else if (go_exec) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (adv) begin
						state_q <= S_ISSUE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			an_q    <= q_item.a_num;
			ad_q    <= q_item.a_den;
			bn_q    <= q_item.b_num;
			bd_q    <= q_item.b_den;
			sub_q   <= q_item.sub;
			pc_q    <= q_item.entry;
			fault_q <= rau_pkg::ERR_NONE;
		end
		if (flt != rau_pkg::ERR_NONE) begin
			fault_q <= flt;
		end
		if (adv) begin
			pc_q <= pc_q + 1'b1;
		end
		if (wr_en) begin
			case (wr_sel)
				rau_pkg::R_T0: t0_q <= wr_val;
				rau_pkg::R_T1: t1_q <= wr_val;
				rau_pkg::R_T2: t2_q <= wr_val;
				default: ;
			endcase
		end
		if (fix_en) begin
			t1_q <= -t1_q;
			t0_q <= -t0_q;
		end
		if (go_exec) begin
			kind_q <= uop.kind;
			dst_q  <= uop.d;
			neg_q  <= opx[rau_pkg::W-1] ^ opy[rau_pkg::W-1];
			prod_q <= rau_pkg::mag(opx) * rau_pkg::mag(opy);
			dq_q   <= rau_pkg::mag(opx);
			dy_q   <= rau_pkg::mag(opy);
			dr_q   <= '0;
			cnt_q  <= '0;
			gx_q   <= rau_pkg::mag(opx);
			gy_q   <= rau_pkg::mag(opy);
			gk_q   <= '0;
		end
		if (state_q == S_EXEC && kind_q == rau_pkg::K_DIV && cnt_q != rau_pkg::DIV_STEPS) begin
			dr_q  <= rem_ge ? rem_diff[rau_pkg::W-1:0] : rem_sh[rau_pkg::W-1:0];
			dq_q  <= {dq_q[rau_pkg::W-2:0], rem_ge};
			cnt_q <= cnt_q + 1'b1;
		end
		// binary gcd: strip common twos, then halve or subtract odd values
		if (state_q == S_EXEC && kind_q == rau_pkg::K_GCD && gx_q != '0 && gy_q != '0) begin
			if (!gx_q[0] && !gy_q[0]) begin
				gx_q <= gx_q >> 1;
				gy_q <= gy_q >> 1;
				gk_q <= gk_q + 1'b1;
			end else if (!gx_q[0]) begin
				gx_q <= gx_q >> 1;
			end else if (!gy_q[0]) begin
				gy_q <= gy_q >> 1;
			end else if (gx_q >= gy_q) begin
				gx_q <= (gx_q - gy_q) >> 1;
			end else begin
				gy_q <= (gy_q - gx_q) >> 1;
			end
		end
		if (out_load) begin
			m_tuser_q <= fault_q;
			if (fault_q != rau_pkg::ERR_NONE) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= rau_pkg::pack_out(t1_q, t0_q);
			end
		end
	end

endmodule

>>> tb/tb_rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit
// Streams fraction operations into the rational arithmetic unit and checks every
// reduced result and error code against a listed value or a bit-accurate predictor,
// with random idle gaps on both stream sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import rau_pkg::*;

	localparam longint unsigned NEG_LIM = 64'h8000_0000;
	localparam longint unsigned POS_LIM = 64'h7fff_ffff;
	localparam int N_RANDOM    = 640;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct {
		logic [1:0]          op;
		logic signed [W-1:0] an;
		logic signed [W-1:0] ad;
		logic signed [W-1:0] bn;
		logic signed [W-1:0] bd;
		bit                  typed;
		logic signed [W-1:0] rn;
		logic signed [W-1:0] rd;
		logic [1:0]          err;
	} op_row_t;

	typedef struct {
		logic signed [W-1:0] num;
		logic signed [W-1:0] den;
		logic [1:0]          err;
	} fraction_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;  // a_num, a_den, b_num, b_den
	logic [1:0]             s_tuser = OP_ADD;  // op
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;  // res_num, res_den
	logic [1:0]             m_tuser;  // error

	fraction_t pending_results[$];
	int        mismatches = 0;
	int        results_seen = 0;
	int        cycles = 0;
	logic [1:0] fault_code;

	rational_arithmetic_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	// ---------------- predictor: sign/magnitude arithmetic with first-fault ----
	function automatic longint unsigned magn(longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint make_val(bit neg, longint unsigned m);
		if (fault_code != ERR_NONE) return 0;
		if (m > (neg ? NEG_LIM : POS_LIM)) begin
			fault_code = ERR_OVF;
			return 0;
		end
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint sm_sum(bit an, longint unsigned am, bit bn,
		longint unsigned bm);
		longint unsigned lim;
		if (fault_code != ERR_NONE) return 0;
		if (an == bn) begin
			lim = an ? NEG_LIM : POS_LIM;
			if (am > lim || bm > lim - am) begin
				fault_code = ERR_OVF;
				return 0;
			end
			return make_val(an, am + bm);
		end
		if (am >= bm) return make_val(an, am - bm);
		return make_val(bn, bm - am);
	endfunction

	function automatic longint f_mul(longint a, longint b);
		bit neg;
		longint unsigned am, bm, lim;
		neg = (a < 0) != (b < 0);
		am = magn(a);
		bm = magn(b);
		lim = neg ? NEG_LIM : POS_LIM;
		if (fault_code != ERR_NONE) return 0;
		if (am != 0 && bm > lim / am) begin
			fault_code = ERR_OVF;
			return 0;
		end
		return make_val(neg, am * bm);
	endfunction

	function automatic longint f_div(longint a, longint b);
		if (fault_code != ERR_NONE) return 0;
		if (b == 0) begin
			fault_code = ERR_DIV0;
			return 0;
		end
		return make_val((a < 0) != (b < 0), magn(a) / magn(b));
	endfunction

	function automatic longint f_gcd(longint a, longint b);
		longint unsigned x, y, t;
		x = longint'(make_val(1'b0, magn(a)));
		y = longint'(make_val(1'b0, magn(b)));
		if (fault_code != ERR_NONE) return 0;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return longint'(x);
	endfunction

	function automatic void reduce_frac(longint n, longint d, output longint rn,
		output longint rd);
		longint g;
		g = f_gcd(n, d);
		n = f_div(n, g);
		d = f_div(d, g);
		if (n < 0 && d < 0) begin
			n = make_val(1'b0, magn(n));
			d = make_val(1'b0, magn(d));
		end
		rn = n;
		rd = d;
	endfunction

	function automatic longint widen(logic [W-1:0] x);
		logic [W-1:0] m;
		m = x[W-1] ? ~x + 1'b1 : x;
		return make_val(x[W-1], longint'({32'b0, m}));
	endfunction

	function automatic fraction_t predict_fraction(op_row_t r);
		longint an, ad, bn, bd, rn, rd, pr, l, t1, t2, s, inv_n, inv_d;
		fraction_t f;
		fault_code = ERR_NONE;
		rn = 0;
		rd = 0;
		an = widen(r.an);
		ad = widen(r.ad);
		bn = widen(r.bn);
		bd = widen(r.bd);
		case (r.op)
			OP_ADD, OP_SUB: begin
				pr = f_mul(ad, bd);
				l  = f_div(pr, f_gcd(ad, bd));
				t1 = f_mul(an, f_div(l, ad));
				t2 = f_mul(bn, f_div(l, bd));
				if (r.op == OP_ADD)
					s = sm_sum(t1 < 0, magn(t1), t2 < 0, magn(t2));
				else
					s = sm_sum(t1 < 0, magn(t1), t2 > 0, magn(t2));
				reduce_frac(s, l, rn, rd);
			end
			OP_MUL: begin
				reduce_frac(f_mul(an, bn), f_mul(ad, bd), rn, rd);
			end
			default: begin
				reduce_frac(bd, bn, inv_n, inv_d);
				t1 = f_mul(an, inv_n);
				t2 = f_mul(ad, inv_d);
				reduce_frac(t1, t2, rn, rd);
			end
		endcase
		if (fault_code != ERR_NONE) begin
			rn = 0;
			rd = 0;
		end
		f.num = W'(rn);
		f.den = W'(rd);
		f.err = fault_code;
		return f;
	endfunction

	// ---------------- stimulus ----------------
	function automatic op_row_t row(logic [1:0] op, int an, int ad, int bn, int bd,
		bit typed = 0, int rn = 0, int rd = 0, logic [1:0] err = ERR_NONE);
		op_row_t r;
		r.op = op; r.an = an; r.ad = ad; r.bn = bn; r.bd = bd;
		r.typed = typed; r.rn = rn; r.rd = rd; r.err = err;
		return r;
	endfunction

	function automatic logic signed [W-1:0] rand_field();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) return $urandom_range(0, 40) - 20;
		if (sel < 8) return $urandom_range(0, 4000) - 2000;
		if (sel < 9) return $urandom();
		return (1 << $urandom_range(0, 30)) * ($urandom_range(0, 1) ? -1 : 1);
	endfunction

	task automatic send(op_row_t r);
		fraction_t f;
		int gap;
		s_tdata  <= {r.bd, r.bn, r.ad, r.an};
		s_tuser  <= r.op;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (r.typed) begin
			f.num = r.rn;
			f.den = r.rd;
			f.err = r.err;
		end else begin
			f = predict_fraction(r);
		end
		pending_results.push_back(f);
		gap = $urandom_range(0, 99);
		gap = gap < 65 ? 0 : gap < 95 ? $urandom_range(1, 4) : $urandom_range(20, 300);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	op_row_t directed[$];

	initial begin
		op_row_t r;
		directed = '{
			row(OP_ADD, 1, 2, 1, 3, 1, 5, 6, ERR_NONE),
			row(OP_SUB, 1, 2, 1, 3, 1, 1, 6, ERR_NONE),
			row(OP_MUL, 2, 3, 3, 4, 1, 1, 2, ERR_NONE),
			row(OP_DIV, 1, 2, 1, 4, 1, 2, 1, ERR_NONE),
			// zero denominator in the lcm path
			row(OP_ADD, 1, 0, 1, 2, 1, 0, 0, ERR_DIV0),
			// gcd of zero and zero
			row(OP_MUL, 0, 1, 5, 0, 1, 0, 0, ERR_DIV0),
			// zero denominator in multiply passes through
			row(OP_MUL, 3, 1, 1, 0, 1, 1, 0, ERR_NONE),
			row(OP_DIV, 1, 2, 0, 1, 1, 1, 0, ERR_NONE),
			// most negative value and overflow
			row(OP_MUL, 32'sh8000_0000, 1, 1, 1, 1, 0, 0, ERR_OVF),
			row(OP_MUL, 65536, 1, 65536, 1, 1, 0, 0, ERR_OVF),
			row(OP_ADD, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1, 1, 0, 0, ERR_OVF),
			// sign handling
			row(OP_MUL, -1, -2, 1, 1, 1, 1, 2, ERR_NONE),
			row(OP_MUL, 1, -2, 1, 1, 1, 1, -2, ERR_NONE),
			row(OP_SUB, -32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, -32'sh7fff_ffff),
			row(OP_DIV, 32'sh7fff_ffff, -32'sh7fff_ffff, -32'sh7fff_ffff, 32'sh7fff_ffff),
			row(OP_ADD, -32'sh7fff_ffff, 3, 32'sh7fff_ffff, 5),
			row(OP_DIV, 5, 32'sh8000_0000, 7, 3),
			row(OP_SUB, 0, 7, 0, 9),
			row(OP_DIV, -6, 4, -9, 12),
			row(OP_ADD, 32'shffff_ffff, 32'shffff_fffe, 32'sh5555_5555, 32'shaaaa_aaab)
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) send(directed[i]);
		repeat (N_RANDOM) begin
			r = row($urandom_range(0, 3), rand_field(), rand_field(), rand_field(),
				rand_field());
			send(r);
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// ---------------- receiver ----------------
	initial begin
		int stall;
		bit held = 0;
		@(posedge arst_n);
		forever begin
			m_tready <= 1'b1;
			@(posedge clk);
			if (!held && results_seen >= 25) begin
				// long hold-off so the input side fills up and backs off
				held = 1;
				m_tready <= 1'b0;
				for (int c = 0; c < 4000; c++) @(posedge clk);
			end else begin
				stall = $urandom_range(0, 99);
				stall = stall < 60 ? 0 : stall < 95 ? $urandom_range(1, 4) :
					$urandom_range(20, 300);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		fraction_t exp_f;
		logic signed [W-1:0] got_n, got_d;
		if (m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			got_n = m_tdata[W-1:0];
			got_d = m_tdata[2*W-1:W];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected transaction %0d/%0d err %0d", $time, got_n, got_d,
					m_tuser);
				mismatches++;
			end else begin
				exp_f = pending_results.pop_front();
				if (got_n !== exp_f.num || got_d !== exp_f.den || m_tuser !== exp_f.err) begin
					$display("%0t: expected %0d/%0d err %0d, got %0d/%0d err %0d", $time,
						exp_f.num, exp_f.den, exp_f.err, got_n, got_d, m_tuser);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule
